// ===== hw/rtl/bldc_pkg.sv =====
// Shared types, constants and the six-step commutation table for the
// hall commutation controller. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bldc_pkg;

    // Event carried by one request
    typedef enum logic [1:0] {
        ACT_HALL_EDGE  = 2'd0,
        ACT_TIMER_TICK = 2'd1,
        ACT_FRAME      = 2'd2,
        ACT_START_POLL = 2'd3
    } action_t;

    // Start-up outcome reported with each result
    typedef enum logic [1:0] {
        START_NONE  = 2'd0,
        START_OK    = 2'd1,
        START_RETRY = 2'd2
    } start_t;

    localparam logic [1:0]  PHASE_NONE        = 2'd3;
    localparam logic [7:0]  FRAME_LEN         = 8'd6;
    localparam logic [7:0]  FRAME_TYPE        = 8'h06;
    localparam logic [7:0]  FRAME_HEAD        = 8'hFE;
    localparam logic [7:0]  FRAME_TAIL        = 8'hFF;
    localparam logic [7:0]  DUTY_IDLE         = 8'hFF;
    localparam logic [7:0]  SPEED_RESET       = 8'd155;
    localparam logic [15:0] WRAP_LIMIT_RESET  = 16'd60000;
    localparam logic [2:0]  STALL_CHECK_TICKS = 3'd6;

    // One input request
    typedef struct packed {
        action_t     action;
        logic [2:0]  hall_state;
        logic [7:0]  frame_length;
        logic [7:0]  frame_head;
        logic [7:0]  frame_type;
        logic [7:0]  frame_speed;
        logic [7:0]  frame_tail;
    } item_t;

    // Configuration registers
    typedef struct packed {
        logic        direction;
        logic [15:0] count_wrap_limit;
    } cfg_t;

    // Controller state
    typedef struct packed {
        logic [1:0]  high_select;
        logic [1:0]  low_select;
        logic [7:0]  duty;
        logic [15:0] edge_count;
        logic [15:0] previous_count;
        logic [2:0]  tick_count;
        logic        stall_flag;
        logic [7:0]  speed_command;
        logic [7:0]  previous_speed;
        logic [7:0]  ramp_duty;
        logic [2:0]  start_hall;
        logic        ramp_active;
        logic        edges_enabled;
        logic        timer_running;
    } state_t;

    // One result
    typedef struct packed {
        logic [1:0] high_phase;
        logic [1:0] low_phase;
        logic [7:0] duty_value;
        logic       stalled;
        start_t     start_result;
    } result_t;

    // Table entry: hold keeps the present drive
    typedef struct packed {
        logic       hold;
        logic [1:0] high;
        logic [1:0] low;
    } phase_sel_t;

    // Six-step table indexed by direction and hall code
    function automatic phase_sel_t six_step(input logic dir, input logic [2:0] hall);
        phase_sel_t sel;
        sel = '{hold: 1'b1, high: PHASE_NONE, low: PHASE_NONE};
        case ({dir, hall})
            4'b0_001: sel = '{hold: 1'b0, high: 2'd0, low: 2'd2};
            4'b0_010: sel = '{hold: 1'b0, high: 2'd2, low: 2'd1};
            4'b0_011: sel = '{hold: 1'b0, high: 2'd0, low: 2'd1};
            4'b0_100: sel = '{hold: 1'b0, high: 2'd1, low: 2'd0};
            4'b0_101: sel = '{hold: 1'b0, high: 2'd1, low: 2'd2};
            4'b0_110: sel = '{hold: 1'b0, high: 2'd2, low: 2'd0};
            4'b1_001: sel = '{hold: 1'b0, high: 2'd2, low: 2'd0};
            4'b1_010: sel = '{hold: 1'b0, high: 2'd1, low: 2'd2};
            4'b1_011: sel = '{hold: 1'b0, high: 2'd1, low: 2'd0};
            4'b1_100: sel = '{hold: 1'b0, high: 2'd0, low: 2'd1};
            4'b1_101: sel = '{hold: 1'b0, high: 2'd2, low: 2'd1};
            4'b1_110: sel = '{hold: 1'b0, high: 2'd0, low: 2'd2};
            default:  sel = '{hold: 1'b1, high: PHASE_NONE, low: PHASE_NONE};
        endcase
        return sel;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bldc_step.sv =====
// Next-state logic of the hall commutation controller: applies one request
// to the present state. Depends on bldc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bldc_step (
    input  wire bldc_pkg::item_t   item,
    input  wire bldc_pkg::cfg_t    cfg,
    input  wire bldc_pkg::state_t  state,
    output bldc_pkg::state_t       state_next,
    output bldc_pkg::start_t       start_result
);
    import bldc_pkg::*;

    phase_sel_t  sel;
    logic        frame_ok;
    logic        speed_ok;
    logic [7:0]  speed_new;
    logic        poll_ok;
    logic        ramp_first;
    logic [2:0]  ramp_hall;
    logic [7:0]  ramp_base;
    logic [7:0]  ramp_dec;
    logic        hall_changed;

    // Decode the lookup and frame checks
    assign sel          = six_step(cfg.direction, item.hall_state);
    assign frame_ok     = (item.frame_length == FRAME_LEN) && (item.frame_type == FRAME_TYPE);
    assign speed_ok     = (item.frame_head == FRAME_HEAD) && (item.frame_tail == FRAME_TAIL);
    assign speed_new    = speed_ok ? item.frame_speed : state.speed_command;
    assign poll_ok      = state.stall_flag && (state.speed_command != 8'd0);
    assign ramp_first   = !state.ramp_active;
    assign ramp_hall    = ramp_first ? item.hall_state : state.start_hall;
    assign ramp_base    = ramp_first ? state.speed_command : state.ramp_duty;
    assign ramp_dec     = ramp_base - 8'd1;
    assign hall_changed = (item.hall_state != ramp_hall);

    // Apply the request
    always_comb begin
        state_next   = state;
        start_result = START_NONE;
        unique case (item.action)
            ACT_HALL_EDGE:
            begin
                if (state.edges_enabled) begin
                    state_next.edge_count = state.edge_count + 16'd1;
                    if (!sel.hold) begin
                        state_next.high_select = sel.high;
                        state_next.low_select  = sel.low;
                    end
                end
            end
            ACT_TIMER_TICK:
            begin
                if (state.timer_running) begin
                    if (state.tick_count >= STALL_CHECK_TICKS) begin
                        if (state.previous_count == state.edge_count) begin
                            state_next.stall_flag = 1'b1;
                        end else begin
                            state_next.previous_count = state.edge_count;
                            state_next.stall_flag     = 1'b0;
                        end
                        state_next.tick_count = 3'd0;
                    end else begin
                        state_next.tick_count = state.tick_count + 3'd1;
                    end
                    if (state.edge_count > cfg.count_wrap_limit) begin
                        state_next.edge_count = 16'd0;
                    end
                end
            end
            ACT_FRAME:
            begin
                if (frame_ok) begin
                    state_next.speed_command = speed_new;
                    if (speed_new != state.previous_speed) begin
                        if (!state.stall_flag) begin
                            state_next.duty = speed_new;
                        end
                        state_next.previous_speed = speed_new;
                    end
                end
            end
            ACT_START_POLL:
            begin
                if (poll_ok) begin
                    // commute on the first sample or on a hall change
                    if ((ramp_first || hall_changed) && !sel.hold) begin
                        state_next.high_select = sel.high;
                        state_next.low_select  = sel.low;
                    end
                    if (ramp_first) begin
                        state_next.tick_count    = 3'd0;
                        state_next.timer_running = 1'b0;
                    end
                    if (hall_changed) begin
                        state_next.edges_enabled = 1'b1;
                        state_next.timer_running = 1'b1;
                        state_next.tick_count    = 3'd0;
                        state_next.duty          = state.speed_command;
                        state_next.stall_flag    = 1'b0;
                        state_next.ramp_active   = 1'b0;
                        state_next.start_hall    = ramp_hall;
                        state_next.ramp_duty     = ramp_base;
                        start_result             = START_OK;
                    end else begin
                        state_next.start_hall = item.hall_state;
                        state_next.ramp_duty  = ramp_dec;
                        if (ramp_dec == 8'd0) begin
                            state_next.duty        = DUTY_IDLE;
                            state_next.ramp_active = 1'b0;
                            start_result           = START_RETRY;
                        end else begin
                            state_next.duty        = ramp_dec;
                            state_next.ramp_active = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bldc_hall_commutation_controller_top.sv =====
// Top level of the sensored BLDC six-step hall commutation controller:
// request register, state, result register and APB registers. Depends on
// bldc_pkg and bldc_step.
//
//  channel   handshake               payload
//  input     in_valid / in_stall     action, hall_state, frame_length..frame_tail
//  output    out_valid / out_stall   high_phase, low_phase, duty_value, stalled,
//                                    start_result
//  config    APB psel/penable/pwrite paddr[2:0], pwdata, prdata, pready
//
// Each request passes through an input register and the next-state logic into
// the result register: one request per cycle sustained while out_stall is low.
// The state updates as the request moves into the result register, so requests
// follow each other with no gap. A stall on the output holds both registers and
// raises in_stall only when the input register is also full. rst_n clears the
// pipeline and loads the controller's power-up state at once.
`timescale 1ns / 1ps
`default_nettype none

module bldc_hall_commutation_controller_top (
    input  wire         clk,
    input  wire         rst_n,
    // input channel
    input  wire         in_valid,
    output logic        in_stall,
    input  wire [1:0]   action,
    input  wire [2:0]   hall_state,
    input  wire [7:0]   frame_length,
    input  wire [7:0]   frame_head,
    input  wire [7:0]   frame_type,
    input  wire [7:0]   frame_speed,
    input  wire [7:0]   frame_tail,
    // output channel
    output logic        out_valid,
    input  wire         out_stall,
    output logic [1:0]  high_phase,
    output logic [1:0]  low_phase,
    output logic [7:0]  duty_value,
    output logic        stalled,
    output logic [1:0]  start_result,
    // configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bldc_pkg::*;

    localparam logic REG_DIRECTION  = 1'b0;
    localparam logic REG_WRAP_LIMIT = 1'b1;

    logic     in_valid_reg;
    item_t    item_reg;
    logic     out_valid_reg;
    result_t  result_reg;
    state_t   state_reg;
    state_t   state_next;
    cfg_t     cfg_reg;
    start_t   step_start;
    logic     out_free;
    logic     advance;
    logic     cfg_write;
    logic     reg_sel;

    // Handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    // Hold the request until it moves on
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (!in_stall && in_valid) begin
            item_reg.action       <= action_t'(action);
            item_reg.hall_state   <= hall_state;
            item_reg.frame_length <= frame_length;
            item_reg.frame_head   <= frame_head;
            item_reg.frame_type   <= frame_type;
            item_reg.frame_speed  <= frame_speed;
            item_reg.frame_tail   <= frame_tail;
        end
    end

    // Next-state logic
    bldc_step u_step (
        .item         (item_reg),
        .cfg          (cfg_reg),
        .state        (state_reg),
        .state_next   (state_next),
        .start_result (step_start)
    );

    // Advance the controller state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg.high_select    <= PHASE_NONE;
            state_reg.low_select     <= PHASE_NONE;
            state_reg.duty           <= DUTY_IDLE;
            state_reg.edge_count     <= 16'd0;
            state_reg.previous_count <= 16'd0;
            state_reg.tick_count     <= 3'd0;
            state_reg.stall_flag     <= 1'b1;
            state_reg.speed_command  <= SPEED_RESET;
            state_reg.previous_speed <= 8'd0;
            state_reg.ramp_duty      <= 8'd0;
            state_reg.start_hall     <= 3'd0;
            state_reg.ramp_active    <= 1'b0;
            state_reg.edges_enabled  <= 1'b0;
            state_reg.timer_running  <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            result_reg.high_phase   <= state_next.high_select;
            result_reg.low_phase    <= state_next.low_select;
            result_reg.duty_value   <= state_next.duty;
            result_reg.stalled      <= state_next.stall_flag;
            result_reg.start_result <= step_start;
        end
    end

    assign out_valid    = out_valid_reg;
    assign high_phase   = result_reg.high_phase;
    assign low_phase    = result_reg.low_phase;
    assign duty_value   = result_reg.duty_value;
    assign stalled      = result_reg.stalled;
    assign start_result = result_reg.start_result;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[2];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.direction        <= 1'b0;
            cfg_reg.count_wrap_limit <= WRAP_LIMIT_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_DIRECTION:  cfg_reg.direction        <= pwdata[0];
                REG_WRAP_LIMIT: cfg_reg.count_wrap_limit <= pwdata[15:0];
                default:        cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_sel)
            REG_DIRECTION:  prdata = {31'd0, cfg_reg.direction};
            REG_WRAP_LIMIT: prdata = {16'd0, cfg_reg.count_wrap_limit};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire
